FILE: rtl/ahms_pkg.sv
`default_nettype none

package ahms_pkg;

  localparam logic [2:0] KIND_TICK       = 3'd0;
  localparam logic [2:0] KIND_HOME       = 3'd1;
  localparam logic [2:0] KIND_GOTO       = 3'd2;
  localparam logic [2:0] KIND_CLEAR_POINT = 3'd3;
  localparam logic [2:0] KIND_HOLD       = 3'd4;

  typedef enum logic [2:0] {
    HOME_IDLE        = 3'd0,
    HOME_RESET       = 3'd1,
    HOME_ALARM_CHECK = 3'd2,
    HOME_WAIT_SVOFF  = 3'd3,
    HOME_WAIT_SVRDY  = 3'd4,
    HOME_SETUP_PULSE = 3'd5,
    HOME_FINAL_WAIT  = 3'd6,
    HOME_DONE        = 3'd7
  } home_state_t;

  typedef enum logic [2:0] {
    MOVE_IDLE       = 3'd0,
    MOVE_READY      = 3'd1,
    MOVE_START      = 3'd2,
    MOVE_WAIT_SERVO = 3'd3,
    MOVE_DRIVE      = 3'd4,
    MOVE_WAIT_BUSY  = 3'd5,
    MOVE_END        = 3'd6
  } move_state_t;

endpackage

`default_nettype wire

FILE: rtl/actuator_homing_and_move_sequencer_core.sv
// A word passes through the input register and then the result register before its result is valid.
// Throughput: one word per cycle while in_stall is low; the input register takes a word
// while a result waits on out_stall, and in_stall rises only when both registers are full.
// Reset (rst, synchronous, active high): both sequences idle, stored point 0,
// done flags clear, request latches low, no word in flight; result outputs are not reset.
`default_nettype none

module actuator_homing_and_move_sequencer_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] kind,
  input  wire logic [2:0] step_number,
  input  wire logic       busy_req,
  input  wire logic       servo_ready,
  input  wire logic       setup_on,
  input  wire logic       in_position,
  input  wire logic       alarm_clear,
  input  wire logic [2:0] point_code,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            servo_on,
  output logic            setup_req,
  output logic            drive_req,
  output logic            reset_req,
  output logic            hold_req,
  output logic [2:0]      point_select,
  output logic            homing_done,
  output logic            move_done,
  output logic            hold_refused,
  output logic [2:0]      homing_phase,
  output logic [2:0]      move_phase
);

  // input register
  logic       s_valid;
  logic [2:0] s_kind;
  logic [2:0] s_step;
  logic       s_busy;
  logic       s_svre;
  logic       s_seton;
  logic       s_inp;
  logic       s_noalarm;
  logic [2:0] s_pos;

  // sequencer state
  ahms_pkg::home_state_t home_state, home_state_next, home_adv;
  ahms_pkg::move_state_t move_state, move_state_next, move_adv;
  logic [2:0] stored_point, stored_point_next;
  logic       move_flag, move_flag_next;
  logic       home_flag, home_flag_next;
  logic       lat_svon, lat_svon_next;
  logic       lat_reset, lat_reset_next;
  logic       lat_drive, lat_drive_next;
  logic       lat_hold, lat_hold_next;
  logic       lat_setup, lat_setup_next;
  logic [2:0] lat_point, lat_point_next;
  logic       refused_next;

  logic out_free;
  logic go_ok;
  logic is_tick;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s_valid && !out_free;
  assign is_tick  = (s_kind == ahms_pkg::KIND_TICK);
  assign go_ok    = (s_kind == ahms_pkg::KIND_GOTO) && (s_step != stored_point) && !s_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
    if (!in_stall) begin
      s_kind    <= kind;
      s_step    <= step_number;
      s_busy    <= busy_req;
      s_svre    <= servo_ready;
      s_seton   <= setup_on;
      s_inp     <= in_position;
      s_noalarm <= alarm_clear;
      s_pos     <= point_code;
    end
  end

  // one homing step
  always_comb begin
    home_adv = home_state;
    case (home_state)
      ahms_pkg::HOME_RESET:       home_adv = ahms_pkg::HOME_ALARM_CHECK;
      ahms_pkg::HOME_ALARM_CHECK: if (!s_busy && s_noalarm) home_adv = ahms_pkg::HOME_WAIT_SVOFF;
      ahms_pkg::HOME_WAIT_SVOFF:  if (!s_svre) home_adv = ahms_pkg::HOME_WAIT_SVRDY;
      ahms_pkg::HOME_WAIT_SVRDY:  if (s_svre) home_adv = ahms_pkg::HOME_SETUP_PULSE;
      ahms_pkg::HOME_SETUP_PULSE: begin
        if (!s_busy || (s_seton && !s_inp)) home_adv = ahms_pkg::HOME_FINAL_WAIT;
      end
      ahms_pkg::HOME_FINAL_WAIT: begin
        if (!s_busy && s_seton && s_inp) home_adv = ahms_pkg::HOME_DONE;
      end
      default: home_adv = home_state;
    endcase
  end

  // one move step; a go-to-point word carries the start request
  always_comb begin
    case (move_state)
      ahms_pkg::MOVE_IDLE:  move_adv = ahms_pkg::MOVE_IDLE;
      ahms_pkg::MOVE_READY: begin
        move_adv = (s_kind == ahms_pkg::KIND_GOTO) ? ahms_pkg::MOVE_START : ahms_pkg::MOVE_READY;
      end
      ahms_pkg::MOVE_START: move_adv = ahms_pkg::MOVE_WAIT_SERVO;
      ahms_pkg::MOVE_WAIT_SERVO: begin
        move_adv = s_svre ? ahms_pkg::MOVE_DRIVE : ahms_pkg::MOVE_WAIT_SERVO;
      end
      ahms_pkg::MOVE_DRIVE: begin
        move_adv = s_busy ? ahms_pkg::MOVE_WAIT_BUSY : ahms_pkg::MOVE_DRIVE;
      end
      ahms_pkg::MOVE_WAIT_BUSY: begin
        move_adv = !s_busy ? ahms_pkg::MOVE_END : ahms_pkg::MOVE_WAIT_BUSY;
      end
      ahms_pkg::MOVE_END:   move_adv = ahms_pkg::MOVE_READY;
      default:              move_adv = ahms_pkg::MOVE_IDLE;
    endcase
  end

  // next state
  always_comb begin
    home_state_next   = home_state;
    move_state_next   = move_state;
    stored_point_next = stored_point;
    move_flag_next    = move_flag;
    home_flag_next    = home_flag;
    case (s_kind)
      ahms_pkg::KIND_TICK: begin
        home_state_next = home_adv;
        move_state_next = move_adv;
        if (s_inp && (s_pos == stored_point)) move_flag_next = 1'b1;
        if (s_inp && (s_pos == 3'd0)) home_flag_next = 1'b1;
      end
      ahms_pkg::KIND_HOME: begin
        home_state_next   = ahms_pkg::HOME_ALARM_CHECK;
        move_state_next   = ahms_pkg::MOVE_READY;
        stored_point_next = 3'd0;
        move_flag_next    = 1'b0;
        home_flag_next    = 1'b0;
      end
      ahms_pkg::KIND_GOTO: begin
        if (go_ok) begin
          move_state_next   = move_adv;
          stored_point_next = s_step;
          move_flag_next    = 1'b0;
        end
      end
      ahms_pkg::KIND_CLEAR_POINT: stored_point_next = 3'd0;
      default: ;
    endcase
  end

  // request lines; the move step is applied after the homing step
  always_comb begin
    lat_svon_next  = lat_svon;
    lat_reset_next = lat_reset;
    lat_drive_next = lat_drive;
    lat_hold_next  = lat_hold;
    lat_setup_next = lat_setup;
    lat_point_next = lat_point;
    refused_next   = 1'b0;
    if (is_tick) begin
      case (home_state)
        ahms_pkg::HOME_RESET: begin
          lat_svon_next  = 1'b0;
          lat_setup_next = 1'b0;
        end
        ahms_pkg::HOME_ALARM_CHECK: lat_reset_next = s_busy || !s_noalarm;
        ahms_pkg::HOME_WAIT_SVOFF:  if (!s_svre) lat_svon_next = 1'b1;
        ahms_pkg::HOME_WAIT_SVRDY:  if (s_svre) lat_setup_next = 1'b1;
        ahms_pkg::HOME_SETUP_PULSE: if (!s_busy || (s_seton && !s_inp)) lat_setup_next = 1'b0;
        default: ;
      endcase
    end
    if (s_kind == ahms_pkg::KIND_HOME) begin
      lat_svon_next  = 1'b0;
      lat_setup_next = 1'b0;
    end
    if (go_ok) lat_point_next = s_step;
    if (is_tick || go_ok) begin
      case (move_state)
        ahms_pkg::MOVE_START:      lat_svon_next = 1'b1;
        ahms_pkg::MOVE_WAIT_SERVO: if (s_svre) lat_drive_next = 1'b1;
        ahms_pkg::MOVE_DRIVE:      lat_drive_next = 1'b0;
        default: ;
      endcase
    end
    if (s_kind == ahms_pkg::KIND_HOLD) begin
      if (!lat_hold && s_busy) begin
        lat_hold_next = 1'b1;
      end else if (lat_hold && !s_busy) begin
        lat_hold_next = 1'b0;
      end else begin
        refused_next = 1'b1;
      end
    end
  end

  logic step_en;
  assign step_en = s_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      home_state   <= ahms_pkg::HOME_IDLE;
      move_state   <= ahms_pkg::MOVE_IDLE;
      stored_point <= 3'd0;
      move_flag    <= 1'b0;
      home_flag    <= 1'b0;
      lat_svon     <= 1'b0;
      lat_reset    <= 1'b0;
      lat_drive    <= 1'b0;
      lat_hold     <= 1'b0;
      lat_setup    <= 1'b0;
      lat_point    <= 3'd0;
      out_valid    <= 1'b0;
    end else begin
      if (step_en) begin
        home_state   <= home_state_next;
        move_state   <= move_state_next;
        stored_point <= stored_point_next;
        move_flag    <= move_flag_next;
        home_flag    <= home_flag_next;
        lat_svon     <= lat_svon_next;
        lat_reset    <= lat_reset_next;
        lat_drive    <= lat_drive_next;
        lat_hold     <= lat_hold_next;
        lat_setup    <= lat_setup_next;
        lat_point    <= lat_point_next;
      end
      if (out_free) out_valid <= s_valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (step_en) begin
      servo_on     <= lat_svon_next;
      setup_req    <= lat_setup_next;
      drive_req    <= lat_drive_next;
      reset_req    <= lat_reset_next;
      hold_req     <= lat_hold_next;
      point_select <= lat_point_next;
      homing_done  <= home_flag_next;
      move_done    <= move_flag_next;
      hold_refused <= refused_next;
      homing_phase <= home_state_next;
      move_phase   <= move_state_next;
    end
  end

endmodule

`default_nettype wire

FILE: dv/sequencer_checker.sv
`timescale 1ns / 1ps

module sequencer_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] kind,
  input  logic [2:0] step_number,
  input  logic       busy_req,
  input  logic       servo_ready,
  input  logic       setup_on,
  input  logic       in_position,
  input  logic       alarm_clear,
  input  logic [2:0] point_code,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       servo_on,
  input  logic       setup_req,
  input  logic       drive_req,
  input  logic       reset_req,
  input  logic       hold_req,
  input  logic [2:0] point_select,
  input  logic       homing_done,
  input  logic       move_done,
  input  logic       hold_refused,
  input  logic [2:0] homing_phase,
  input  logic [2:0] move_phase,
  output int         mismatches,
  output int         pending,
  output int         results
);

  typedef struct packed {
    logic       servo_on;
    logic       setup_req;
    logic       drive_req;
    logic       reset_req;
    logic       hold_req;
    logic [2:0] point_select;
    logic       homing_done;
    logic       move_done;
    logic       hold_refused;
    logic [2:0] homing_phase;
    logic [2:0] move_phase;
  } status_word_t;

  status_word_t status_q[$];

  // shadow of the sequencer
  ahms_pkg::home_state_t home_st;
  ahms_pkg::move_state_t move_st;
  logic [2:0]  stored_pt;
  logic        hm_done_f;
  logic        mv_done_f;
  logic        svon_l;
  logic        reset_l;
  logic        drive_l;
  logic        hold_l;
  logic        setup_l;
  logic [2:0]  psel_l;

  initial begin
    mismatches = 0;
    pending = 0;
    results = 0;
  end

  function automatic void clear_shadow();
    home_st = ahms_pkg::HOME_IDLE;
    move_st = ahms_pkg::MOVE_IDLE;
    stored_pt = '0;
    hm_done_f = 1'b0;
    mv_done_f = 1'b0;
    svon_l = 1'b0;
    reset_l = 1'b0;
    drive_l = 1'b0;
    hold_l = 1'b0;
    setup_l = 1'b0;
    psel_l = '0;
  endfunction

  function automatic void advance_move(logic start, logic busy, logic svre);
    case (move_st)
      ahms_pkg::MOVE_IDLE: ;
      ahms_pkg::MOVE_READY: if (start) move_st = ahms_pkg::MOVE_START;
      ahms_pkg::MOVE_START: begin
        svon_l = 1'b1;
        move_st = ahms_pkg::MOVE_WAIT_SERVO;
      end
      ahms_pkg::MOVE_WAIT_SERVO: if (svre) begin
        drive_l = 1'b1;
        move_st = ahms_pkg::MOVE_DRIVE;
      end
      ahms_pkg::MOVE_DRIVE: begin
        if (busy) move_st = ahms_pkg::MOVE_WAIT_BUSY;
        drive_l = 1'b0;
      end
      ahms_pkg::MOVE_WAIT_BUSY: if (!busy) move_st = ahms_pkg::MOVE_END;
      ahms_pkg::MOVE_END: move_st = ahms_pkg::MOVE_READY;
      default: move_st = ahms_pkg::MOVE_IDLE;
    endcase
  endfunction

  function automatic void advance_homing(logic busy, logic svre, logic seton, logic inp,
                                         logic noalarm);
    case (home_st)
      ahms_pkg::HOME_RESET: begin
        svon_l = 1'b0;
        setup_l = 1'b0;
        home_st = ahms_pkg::HOME_ALARM_CHECK;
      end
      ahms_pkg::HOME_ALARM_CHECK: begin
        if (busy || !noalarm) begin
          reset_l = 1'b1;
        end else begin
          reset_l = 1'b0;
          home_st = ahms_pkg::HOME_WAIT_SVOFF;
        end
      end
      ahms_pkg::HOME_WAIT_SVOFF: if (!svre) begin
        svon_l = 1'b1;
        home_st = ahms_pkg::HOME_WAIT_SVRDY;
      end
      ahms_pkg::HOME_WAIT_SVRDY: if (svre) begin
        setup_l = 1'b1;
        home_st = ahms_pkg::HOME_SETUP_PULSE;
      end
      ahms_pkg::HOME_SETUP_PULSE: if (!busy || (seton && !inp)) begin
        setup_l = 1'b0;
        home_st = ahms_pkg::HOME_FINAL_WAIT;
      end
      ahms_pkg::HOME_FINAL_WAIT: if (!busy && seton && inp) home_st = ahms_pkg::HOME_DONE;
      default: ;
    endcase
  endfunction

  function automatic status_word_t predict_status(logic [2:0] k, logic [2:0] req, logic busy,
                                                  logic svre, logic seton, logic inp,
                                                  logic noalarm, logic [2:0] pos);
    status_word_t w;
    logic refused;
    refused = 1'b0;
    case (k)
      ahms_pkg::KIND_TICK: begin
        advance_homing(busy, svre, seton, inp, noalarm);
        advance_move(1'b0, busy, svre);
        if (inp && pos == stored_pt) mv_done_f = 1'b1;
        if (inp && pos == 3'd0) hm_done_f = 1'b1;
      end
      ahms_pkg::KIND_HOME: begin
        mv_done_f = 1'b0;
        hm_done_f = 1'b0;
        move_st = ahms_pkg::MOVE_READY;
        home_st = ahms_pkg::HOME_RESET;
        advance_homing(busy, svre, seton, inp, noalarm);
        stored_pt = '0;
      end
      ahms_pkg::KIND_GOTO: begin
        if (req != stored_pt && !busy) begin
          mv_done_f = 1'b0;
          stored_pt = req;
          psel_l = req;
          advance_move(1'b1, busy, svre);
        end
      end
      ahms_pkg::KIND_CLEAR_POINT: stored_pt = '0;
      ahms_pkg::KIND_HOLD: begin
        if (!hold_l && busy) hold_l = 1'b1;
        else if (hold_l && !busy) hold_l = 1'b0;
        else refused = 1'b1;
      end
      default: ;
    endcase
    w.servo_on = svon_l;
    w.setup_req = setup_l;
    w.drive_req = drive_l;
    w.reset_req = reset_l;
    w.hold_req = hold_l;
    w.point_select = psel_l;
    w.homing_done = hm_done_f;
    w.move_done = mv_done_f;
    w.hold_refused = refused;
    w.homing_phase = home_st;
    w.move_phase = move_st;
    return w;
  endfunction

  function automatic string field_diff(string name, logic [2:0] want, logic [2:0] seen);
    if (want === seen) return "";
    return $sformatf(" %s exp %0d got %0d", name, want, seen);
  endfunction

  always @(posedge clk) begin : watch
    status_word_t want;
    string diffs;
    if (rst) begin
      clear_shadow();
      status_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results++;
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with no input word waiting", $realtime);
        end else begin
          want = status_q.pop_front();
          diffs = {field_diff("servo_on", 3'(want.servo_on), 3'(servo_on)),
                   field_diff("setup_req", 3'(want.setup_req), 3'(setup_req)),
                   field_diff("drive_req", 3'(want.drive_req), 3'(drive_req)),
                   field_diff("reset_req", 3'(want.reset_req), 3'(reset_req)),
                   field_diff("hold_req", 3'(want.hold_req), 3'(hold_req)),
                   field_diff("point_select", want.point_select, point_select),
                   field_diff("homing_done", 3'(want.homing_done), 3'(homing_done)),
                   field_diff("move_done", 3'(want.move_done), 3'(move_done)),
                   field_diff("hold_refused", 3'(want.hold_refused), 3'(hold_refused)),
                   field_diff("homing_phase", want.homing_phase, homing_phase),
                   field_diff("move_phase", want.move_phase, move_phase)};
          if (diffs != "") begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d mismatch:%s", $realtime, results, diffs);
          end
        end
      end
      if (in_valid && !in_stall)
        status_q.push_back(predict_status(kind, step_number, busy_req, servo_ready, setup_on,
                                          in_position, alarm_clear, point_code));
    end
    pending = status_q.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // kinds with no function in the block
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int HOLD_OFF_CYCLES = 80;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] kind = '0;
  logic [2:0] step_number = '0;
  logic       busy_req = 1'b0;
  logic       servo_ready = 1'b0;
  logic       setup_on = 1'b0;
  logic       in_position = 1'b0;
  logic       alarm_clear = 1'b0;
  logic [2:0] point_code = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       servo_on;
  logic       setup_req;
  logic       drive_req;
  logic       reset_req;
  logic       hold_req;
  logic [2:0] point_select;
  logic       homing_done;
  logic       move_done;
  logic       hold_refused;
  logic [2:0] homing_phase;
  logic [2:0] move_phase;

  int mismatches;
  int pending;
  int results;

  int   words_sent = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_armed = 1'b0;
  logic long_hold = 1'b0;

  actuator_homing_and_move_sequencer_core u_top (.*);
  sequencer_checker u_checker (.*);

  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (long_hold) out_stall = 1'b1;
    else out_stall = ($urandom_range(0, 99) < recv_stall_pct);
  end

  // long output hold so the block backs up and stalls its input
  initial begin
    wait (hold_armed);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #400000;
    $display("testbench failed");
    $finish;
  end

  function automatic logic coin();
    return $urandom_range(0, 1) != 0;
  endfunction

  // entered and left at a falling edge
  task automatic send_word(logic [2:0] k, logic [2:0] sn, logic b, logic sr, logic so,
                           logic ip, logic ac, logic [2:0] pc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    kind = k;
    step_number = sn;
    busy_req = b;
    servo_ready = sr;
    setup_on = so;
    in_position = ip;
    alarm_clear = ac;
    point_code = pc;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_noise();
    send_word(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), coin(), coin(), coin(),
              coin(), coin(), 3'($urandom_range(0, 7)));
  endtask

  // tick with the given status lines; now and then a stray word breaks the sequence
  task automatic poll_tick(logic b, logic sr, logic so, logic ip, logic ac, logic [2:0] pc);
    if ($urandom_range(0, 9) == 0) send_noise();
    send_word(ahms_pkg::KIND_TICK, 3'($urandom_range(0, 7)), b, sr, so, ip, ac, pc);
  endtask

  task automatic homing_run();
    send_word(ahms_pkg::KIND_HOME, 3'($urandom_range(0, 7)), coin(), coin(), coin(), coin(),
              coin(), 3'($urandom_range(0, 7)));
    if (coin()) poll_tick(coin(), coin(), coin(), coin(), 1'b0, 3'($urandom_range(0, 7)));
    poll_tick(1'b0, coin(), coin(), coin(), 1'b1, 3'($urandom_range(0, 7)));
    poll_tick(coin(), 1'b0, coin(), coin(), coin(), 3'($urandom_range(0, 7)));
    poll_tick(coin(), 1'b1, coin(), coin(), coin(), 3'($urandom_range(0, 7)));
    if (coin()) poll_tick(1'b1, coin(), 1'b1, 1'b0, coin(), 3'($urandom_range(0, 7)));
    else poll_tick(1'b0, coin(), coin(), coin(), coin(), 3'($urandom_range(0, 7)));
    poll_tick(1'b0, coin(), 1'b1, 1'b1, coin(), coin() ? 3'd0 : 3'($urandom_range(0, 7)));
  endtask

  task automatic move_run();
    logic [2:0] pt;
    pt = 3'($urandom_range(0, 7));
    send_word(ahms_pkg::KIND_GOTO, pt, 1'b0, coin(), coin(), coin(), coin(),
              3'($urandom_range(0, 7)));
    poll_tick(coin(), coin(), coin(), coin(), coin(), 3'($urandom_range(0, 7)));
    poll_tick(coin(), 1'b1, coin(), coin(), coin(), 3'($urandom_range(0, 7)));
    poll_tick(1'b1, coin(), coin(), coin(), coin(), 3'($urandom_range(0, 7)));
    if (coin())
      send_word(ahms_pkg::KIND_HOLD, 3'($urandom_range(0, 7)), 1'b1, coin(), coin(), coin(),
                coin(), 3'($urandom_range(0, 7)));
    poll_tick(1'b0, coin(), coin(), coin(), coin(), 3'($urandom_range(0, 7)));
    if (coin())
      send_word(ahms_pkg::KIND_HOLD, 3'($urandom_range(0, 7)), 1'b0, coin(), coin(), coin(),
                coin(), 3'($urandom_range(0, 7)));
    poll_tick(coin(), coin(), coin(), coin(), coin(), 3'($urandom_range(0, 7)));
    poll_tick(coin(), coin(), coin(), 1'b1, coin(), coin() ? pt : 3'($urandom_range(0, 7)));
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int target);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (words_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: homing_run();
        3, 4, 5, 6: move_run();
        7: begin
          send_word(ahms_pkg::KIND_HOLD, 3'($urandom_range(0, 7)), coin(), coin(), coin(),
                    coin(), coin(), 3'($urandom_range(0, 7)));
          send_word(ahms_pkg::KIND_HOLD, 3'($urandom_range(0, 7)), coin(), coin(), coin(),
                    coin(), coin(), 3'($urandom_range(0, 7)));
        end
        default: repeat ($urandom_range(1, 4)) send_noise();
      endcase
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed: idle commands, hold toggling, homing and one full move
    send_word(ahms_pkg::KIND_TICK, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_word(ahms_pkg::KIND_HOLD, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_word(ahms_pkg::KIND_HOLD, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_word(ahms_pkg::KIND_HOLD, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_word(ahms_pkg::KIND_HOLD, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_word(ahms_pkg::KIND_GOTO, 3'd3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_word(ahms_pkg::KIND_GOTO, 3'd3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_word(ahms_pkg::KIND_GOTO, 3'd5, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_word(ahms_pkg::KIND_CLEAR_POINT, 3'd7, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 3'd7);
    send_word(KIND_SPARE_LO, 3'd7, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 3'd7);
    send_word(KIND_SPARE_HI, 3'd7, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 3'd7);
    send_word(ahms_pkg::KIND_HOME, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0);
    send_word(ahms_pkg::KIND_TICK, 3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 3'd4);
    send_word(ahms_pkg::KIND_TICK, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 3'd4);
    send_word(ahms_pkg::KIND_TICK, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 3'd4);
    send_word(ahms_pkg::KIND_TICK, 3'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 3'd4);
    send_word(ahms_pkg::KIND_TICK, 3'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 3'd4);
    send_word(ahms_pkg::KIND_TICK, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 3'd4);
    send_word(ahms_pkg::KIND_TICK, 3'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 3'd0);
    send_word(ahms_pkg::KIND_GOTO, 3'd7, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 3'd0);
    send_word(ahms_pkg::KIND_TICK, 3'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 3'd0);
    send_word(ahms_pkg::KIND_TICK, 3'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 3'd0);
    send_word(ahms_pkg::KIND_TICK, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 3'd0);
    send_word(ahms_pkg::KIND_TICK, 3'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 3'd0);
    send_word(ahms_pkg::KIND_TICK, 3'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 3'd7);

    run_phase(0, 0, 300);
    hold_armed = 1'b1;
    run_phase(0, 0, 340);
    run_phase(69, 0, 560);
    run_phase(0, 69, 780);
    run_phase(37, 37, 1000);
    run_phase(0, 0, 1160);

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);

    $display("Sent %0d words, checked %0d results", words_sent, results);
    $display("Mixes: no idling, %0d cycle output hold, sender/receiver/both idling",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ahms_pkg.sv
rtl/actuator_homing_and_move_sequencer_core.sv
dv/sequencer_checker.sv
dv/testbench.sv
